FILE: rtl/rpe_pkg.sv
// Shared types and constants for the relative pose block.
// No dependencies; imported by the interfaces and by every module.
package rpe_pkg;

    localparam int ROT_FRAC_BITS = 14;
    localparam int Q30_BITS      = 30;
    localparam int SC_SHIFT      = Q30_BITS - ROT_FRAC_BITS;
    localparam int SCALE_SHIFT   = 15;

    localparam logic [15:0] SCALE_RESET = 16'd1638;

    typedef struct packed {
        logic signed [15:0] angle_x;
        logic signed [15:0] angle_y;
        logic signed [15:0] angle_z;
        logic signed [31:0] shift_x;
        logic signed [31:0] shift_y;
        logic signed [31:0] shift_z;
    } pose_t;

    // queued item: pose plus the first-frame tag set by the front end
    typedef struct packed {
        pose_t pose;
        logic  first;
    } qitem_t;

    typedef struct packed {
        logic valid;
    } qctl_t;

endpackage

FILE: rtl/rpe_if.sv
// Handshake channels of the relative pose block: pose in, result out, config.
// Depends on rpe_pkg.
interface rpe_in_if import rpe_pkg::*; ();
    logic               valid;
    logic               ready;
    logic signed [15:0] angle_x;
    logic signed [15:0] angle_y;
    logic signed [15:0] angle_z;
    logic signed [31:0] shift_x;
    logic signed [31:0] shift_y;
    logic signed [31:0] shift_z;

    modport source (output valid, angle_x, angle_y, angle_z, shift_x, shift_y, shift_z,
                    input ready);
    modport sink (input valid, angle_x, angle_y, angle_z, shift_x, shift_y, shift_z,
                  output ready);
endinterface

interface rpe_out_if import rpe_pkg::*; ();
    logic               valid;
    logic               ready;
    logic signed [15:0] r00;
    logic signed [15:0] r01;
    logic signed [15:0] r02;
    logic signed [15:0] r10;
    logic signed [15:0] r11;
    logic signed [15:0] r12;
    logic signed [15:0] r20;
    logic signed [15:0] r21;
    logic signed [15:0] r22;
    logic signed [31:0] out_tx;
    logic signed [31:0] out_ty;
    logic signed [31:0] out_tz;

    modport source (output valid, r00, r01, r02, r10, r11, r12, r20, r21, r22,
                    out_tx, out_ty, out_tz, input ready);
    modport sink (input valid, r00, r01, r02, r10, r11, r12, r20, r21, r22,
                  out_tx, out_ty, out_tz, output ready);
endinterface

interface rpe_cfg_if import rpe_pkg::*; ();
    logic        valid;
    logic        ready;
    logic [15:0] data;

    modport source (output valid, data, input ready);
    modport sink (input valid, data, output ready);
endinterface

FILE: rtl/rpe_front.sv
// Front end: accepts pose items, tags the first frame after reset, and
// holds them in a two-entry queue for the back end. Depends on rpe_pkg, rpe_if.
module rpe_front import rpe_pkg::*; (
    input  logic     clk,
    input  logic     rst_n,
    rpe_in_if.sink   pose,
    output qitem_t   q_item,
    output qctl_t    q_stat,
    input  logic     q_pop
);

    qitem_t     fifo_reg [2];
    logic       wr_ptr_reg;
    logic       rd_ptr_reg;
    logic [1:0] count_reg;
    logic       first_reg;
    logic       push;
    pose_t      in_pose;

    assign pose.ready = (count_reg != 2'd2);
    assign push       = pose.valid && pose.ready;

    assign in_pose.angle_x = pose.angle_x;
    assign in_pose.angle_y = pose.angle_y;
    assign in_pose.angle_z = pose.angle_z;
    assign in_pose.shift_x = pose.shift_x;
    assign in_pose.shift_y = pose.shift_y;
    assign in_pose.shift_z = pose.shift_z;

    assign q_item       = fifo_reg[rd_ptr_reg];
    assign q_stat.valid = (count_reg != 2'd0);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
            first_reg  <= 1'b1;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= ~wr_ptr_reg;
                first_reg  <= 1'b0;
            end
            if (q_pop)
                rd_ptr_reg <= ~rd_ptr_reg;
            if (push && !q_pop)
                count_reg <= count_reg + 2'd1;
            else if (!push && q_pop)
                count_reg <= count_reg - 2'd1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            fifo_reg[wr_ptr_reg].pose  <= in_pose;
            fifo_reg[wr_ptr_reg].first <= first_reg;
        end
    end

endmodule

FILE: rtl/rpe_back.sv
// Back end: sequencer around one shared multiplier. Evaluates sine/cosine
// series, the rotation products and the relative transform, then holds the
// result in an output register. Depends on rpe_pkg, rpe_if.
module rpe_back import rpe_pkg::*; (
    input  logic        clk,
    input  logic        rst_n,
    input  qitem_t      q_item,
    input  qctl_t       q_stat,
    output logic        q_pop,
    input  logic [15:0] scale,
    rpe_out_if.source   result
);

    localparam int MW = 35;
    localparam int PW = 2 * MW;
    localparam int AW = 52;

    localparam logic signed [36:0] PI_Q30  = 37'sd3373259426;
    localparam logic signed [33:0] ONE_Q30 = 34'sd1073741824;
    localparam logic signed [15:0] ONE_ROT = 16'(1 << ROT_FRAC_BITS);
    localparam logic [64:0] RECIP_BASE = 65'h1_0000_0000;
    localparam logic [3:0] SIN_LAST = 4'd4;
    localparam logic [3:0] COS_LAST = 4'd10;

    localparam logic [3:0] ST_IDLE  = 4'd0;
    localparam logic [3:0] ST_PREP  = 4'd1;
    localparam logic [3:0] ST_SQ    = 4'd2;
    localparam logic [3:0] ST_SQR   = 4'd3;
    localparam logic [3:0] ST_M1    = 4'd4;
    localparam logic [3:0] ST_M2    = 4'd5;
    localparam logic [3:0] ST_M3    = 4'd6;
    localparam logic [3:0] ST_SF    = 4'd7;
    localparam logic [3:0] ST_SR    = 4'd8;
    localparam logic [3:0] ST_SCEND = 4'd9;
    localparam logic [3:0] ST_MAT   = 4'd10;
    localparam logic [3:0] ST_MWAIT = 4'd11;
    localparam logic [3:0] ST_FIRST = 4'd12;
    localparam logic [3:0] ST_DONE  = 4'd13;

    localparam logic [2:0] PH_XZ  = 3'd0;
    localparam logic [2:0] PH_YM  = 3'd1;
    localparam logic [2:0] PH_REL = 3'd2;
    localparam logic [2:0] PH_TS  = 3'd3;
    localparam logic [2:0] PH_TR  = 3'd4;

    // series step: divisors k*(k+1), sine steps first, then cosine
    function automatic logic [7:0] series_div(input logic [3:0] idx);
        logic [7:0] d;
        unique case (idx)
            4'd0:    d = 8'd110;
            4'd1:    d = 8'd72;
            4'd2:    d = 8'd42;
            4'd3:    d = 8'd20;
            4'd4:    d = 8'd6;
            4'd5:    d = 8'd132;
            4'd6:    d = 8'd90;
            4'd7:    d = 8'd56;
            4'd8:    d = 8'd30;
            4'd9:    d = 8'd12;
            default: d = 8'd2;
        endcase
        return d;
    endfunction

    // floor(2^32 / divisor)
    function automatic logic [31:0] series_recip(input logic [3:0] idx);
        logic [31:0] m;
        unique case (idx)
            4'd0:    m = 32'(RECIP_BASE / 110);
            4'd1:    m = 32'(RECIP_BASE / 72);
            4'd2:    m = 32'(RECIP_BASE / 42);
            4'd3:    m = 32'(RECIP_BASE / 20);
            4'd4:    m = 32'(RECIP_BASE / 6);
            4'd5:    m = 32'(RECIP_BASE / 132);
            4'd6:    m = 32'(RECIP_BASE / 90);
            4'd7:    m = 32'(RECIP_BASE / 56);
            4'd8:    m = 32'(RECIP_BASE / 30);
            4'd9:    m = 32'(RECIP_BASE / 12);
            default: m = 32'(RECIP_BASE / 2);
        endcase
        return m;
    endfunction

    function automatic logic signed [15:0] sat16(input logic signed [AW:0] v);
        logic signed [15:0] r;
        if (v > (AW+1)'(32767))
            r = 16'sd32767;
        else if (v < -(AW+1)'(32768))
            r = -16'sd32768;
        else
            r = 16'(v);
        return r;
    endfunction

    function automatic logic signed [31:0] sat32(input logic signed [AW:0] v);
        logic signed [31:0] r;
        if (v > (AW+1)'(64'sd2147483647))
            r = 32'sh7fffffff;
        else if (v < -(AW+1)'(64'sd2147483648))
            r = 32'sh80000000;
        else
            r = 32'(v);
        return r;
    endfunction

    logic [3:0]  state_reg, state_next;
    pose_t       pose_reg;
    logic        first_reg;
    logic [1:0]  ang_reg;
    logic [3:0]  idx_reg;
    logic signed [32:0] ax_reg;
    logic        negx_reg, flip_reg;
    logic signed [33:0] x2_reg;
    logic signed [33:0] p_reg;
    logic [31:0] vabs_reg;
    logic        vneg_reg;
    logic signed [33:0] s_reg;
    logic signed [15:0] sc_reg [6];
    logic signed [PW-1:0] prod_reg;

    logic signed [15:0] rxz_reg [9];
    logic signed [15:0] r_reg [9];
    logic signed [15:0] rel_reg [9];
    logic signed [15:0] prev_rot_reg [9];
    logic signed [31:0] prev_t_reg [3];
    logic signed [31:0] tn_reg [3];
    logic signed [31:0] tr_reg [3];
    logic signed [15:0] orot_reg [9];
    logic signed [31:0] otr_reg [3];
    logic        out_valid_reg;

    logic [2:0]  ph_reg;
    logic [1:0]  ei_reg, ej_reg, ek_reg;
    logic        mv_reg, mfirst_reg, mlast_reg;
    logic [2:0]  mph_reg;
    logic [1:0]  mi_reg, mj_reg;
    logic signed [AW-1:0] acc_reg;

    logic signed [MW-1:0] mul_a, mul_b;
    logic signed [PW-1:0] rnd30;
    logic signed [15:0] cur_angle;
    logic signed [36:0] xq, xr, x2q;
    logic signed [33:0] vs;
    logic [31:0] q0;
    logic [39:0] dq;
    logic signed [40:0] remv;
    logic [31:0] qv;
    logic signed [33:0] sqv;
    logic signed [33:0] sin_f, cos_f, sin_r, cos_r;
    logic signed [15:0] rx [9];
    logic signed [15:0] ry [9];
    logic signed [15:0] rz [9];
    logic signed [31:0] tin [3];
    logic [3:0]  ik, kj, jk;
    logic [1:0]  last_k, last_j;
    logic        is_last_term, is_last_all;
    logic signed [AW-1:0] sum;
    logic signed [AW-1:0] r14, r15;
    logic [3:0]  widx;
    logic        done_fire;

    assign q_pop     = (state_reg == ST_IDLE) && q_stat.valid;
    assign done_fire = (state_reg == ST_DONE) && (!out_valid_reg || result.ready);

    always_comb
    begin
        unique case (ang_reg)
            2'd0:    cur_angle = pose_reg.angle_x;
            2'd1:    cur_angle = pose_reg.angle_y;
            default: cur_angle = pose_reg.angle_z;
        endcase
    end

    assign xq  = 37'(cur_angle) <<< 17;
    assign x2q = xq <<< 1;

    always_comb
    begin
        if (x2q > PI_Q30)
            xr = xq - PI_Q30;
        else if (x2q < -PI_Q30)
            xr = xq + PI_Q30;
        else
            xr = xq;
    end

    assign rnd30 = (prod_reg + (PW'(1) <<< (Q30_BITS - 1))) >>> Q30_BITS;
    assign vs    = 34'(rnd30);

    // quotient estimate is low by at most one; one compare fixes it
    assign q0   = prod_reg[63:32];
    assign dq   = 40'(q0) * 40'(series_div(idx_reg));
    assign remv = 41'(vabs_reg) - 41'(dq);
    assign qv   = (remv >= 41'(series_div(idx_reg))) ? q0 + 32'd1 : q0;
    assign sqv  = vneg_reg ? -34'(qv) : 34'(qv);

    assign sin_f = flip_reg ? -s_reg : s_reg;
    assign cos_f = flip_reg ? -p_reg : p_reg;
    assign sin_r = (sin_f + (34'sd1 <<< (SC_SHIFT - 1))) >>> SC_SHIFT;
    assign cos_r = (cos_f + (34'sd1 <<< (SC_SHIFT - 1))) >>> SC_SHIFT;

    assign rx[0] = ONE_ROT;    assign rx[1] = '0;         assign rx[2] = '0;
    assign rx[3] = '0;         assign rx[4] = sc_reg[1];  assign rx[5] = -sc_reg[0];
    assign rx[6] = '0;         assign rx[7] = sc_reg[0];  assign rx[8] = sc_reg[1];
    assign ry[0] = sc_reg[3];  assign ry[1] = '0;         assign ry[2] = sc_reg[2];
    assign ry[3] = '0;         assign ry[4] = ONE_ROT;    assign ry[5] = '0;
    assign ry[6] = -sc_reg[2]; assign ry[7] = '0;         assign ry[8] = sc_reg[3];
    assign rz[0] = sc_reg[5];  assign rz[1] = -sc_reg[4]; assign rz[2] = '0;
    assign rz[3] = sc_reg[4];  assign rz[4] = sc_reg[5];  assign rz[5] = '0;
    assign rz[6] = '0;         assign rz[7] = '0;         assign rz[8] = ONE_ROT;

    assign tin[0] = pose_reg.shift_x;
    assign tin[1] = pose_reg.shift_y;
    assign tin[2] = pose_reg.shift_z;

    assign ik = 4'(ei_reg) * 4'd3 + 4'(ek_reg);
    assign kj = 4'(ek_reg) * 4'd3 + 4'(ej_reg);
    assign jk = 4'(ej_reg) * 4'd3 + 4'(ek_reg);
    assign last_k = (ph_reg == PH_TS) ? 2'd0 : 2'd2;
    assign last_j = (ph_reg == PH_TS || ph_reg == PH_TR) ? 2'd0 : 2'd2;
    assign is_last_term = (ek_reg == last_k);
    assign is_last_all  = is_last_term && (ej_reg == last_j) && (ei_reg == 2'd2);

    // shared multiplier operand select
    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        unique case (state_reg)
            ST_SQ:
            begin
                mul_a = MW'(ax_reg);
                mul_b = MW'(ax_reg);
            end
            ST_M1:
            begin
                mul_a = MW'(p_reg);
                mul_b = MW'(x2_reg);
            end
            ST_M2:
            begin
                mul_a = MW'(vs < 0 ? -vs : vs);
                mul_b = MW'({1'b0, series_recip(idx_reg)});
            end
            ST_SF:
            begin
                mul_a = MW'(ax_reg);
                mul_b = MW'(p_reg);
            end
            ST_MAT:
            begin
                case (ph_reg)
                    PH_XZ:
                    begin
                        mul_a = MW'(rx[ik]);
                        mul_b = MW'(rz[kj]);
                    end
                    PH_YM:
                    begin
                        mul_a = MW'(ry[ik]);
                        mul_b = MW'(rxz_reg[kj]);
                    end
                    PH_REL:
                    begin
                        mul_a = MW'(r_reg[ik]);
                        mul_b = MW'(prev_rot_reg[jk]);
                    end
                    PH_TS:
                    begin
                        mul_a = MW'(tin[ei_reg]);
                        mul_b = MW'({1'b0, scale});
                    end
                    default:
                    begin
                        mul_a = MW'(rel_reg[ik]);
                        mul_b = MW'(prev_t_reg[ek_reg]);
                    end
                endcase
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign sum  = (mfirst_reg ? AW'(0) : acc_reg) + AW'(prod_reg);
    assign r14  = (sum + (AW'(1) <<< (ROT_FRAC_BITS - 1))) >>> ROT_FRAC_BITS;
    assign r15  = (sum + (AW'(1) <<< (SCALE_SHIFT - 1))) >>> SCALE_SHIFT;
    assign widx = 4'(mi_reg) * 4'd3 + 4'(mj_reg);

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:  if (q_stat.valid) state_next = ST_PREP;
            ST_PREP:  state_next = ST_SQ;
            ST_SQ:    state_next = ST_SQR;
            ST_SQR:   state_next = ST_M1;
            ST_M1:    state_next = ST_M2;
            ST_M2:    state_next = ST_M3;
            ST_M3:
            begin
                if (idx_reg == SIN_LAST)
                    state_next = ST_SF;
                else if (idx_reg == COS_LAST)
                    state_next = ST_SCEND;
                else
                    state_next = ST_M1;
            end
            ST_SF:    state_next = ST_SR;
            ST_SR:    state_next = ST_M1;
            ST_SCEND: state_next = (ang_reg == 2'd2) ? ST_MAT : ST_PREP;
            ST_MAT:   if (is_last_all) state_next = ST_MWAIT;
            ST_MWAIT:
            begin
                if (ph_reg == PH_XZ)
                    state_next = ST_MAT;
                else if (ph_reg == PH_YM)
                    state_next = first_reg ? ST_FIRST : ST_MAT;
                else if (ph_reg == PH_TR)
                    state_next = ST_DONE;
                else
                    state_next = ST_MAT;
            end
            ST_FIRST: state_next = ST_DONE;
            ST_DONE:  if (done_fire) state_next = ST_IDLE;
            default:  state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
            mv_reg        <= 1'b0;
            for (int i = 0; i < 9; i++)
                prev_rot_reg[i] <= '0;
            for (int i = 0; i < 3; i++)
                prev_t_reg[i] <= '0;
        end
        else
        begin
            state_reg <= state_next;
            mv_reg    <= (state_reg == ST_MAT);
            if (done_fire)
            begin
                out_valid_reg <= 1'b1;
                for (int i = 0; i < 9; i++)
                    prev_rot_reg[i] <= r_reg[i];
                for (int i = 0; i < 3; i++)
                    prev_t_reg[i] <= tn_reg[i];
            end
            else if (result.valid && result.ready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        prod_reg <= mul_a * mul_b;
        unique case (state_reg)
            ST_IDLE:
            begin
                pose_reg  <= q_item.pose;
                first_reg <= q_item.first;
                ang_reg   <= 2'd0;
            end
            ST_PREP:
            begin
                flip_reg <= (x2q > PI_Q30) || (x2q < -PI_Q30);
                negx_reg <= xr < 0;
                ax_reg   <= 33'(xr < 0 ? -xr : xr);
                idx_reg  <= 4'd0;
            end
            ST_SQR:
            begin
                x2_reg <= vs;
                p_reg  <= ONE_Q30;
            end
            ST_M2:
            begin
                vneg_reg <= vs < 0;
                vabs_reg <= 32'(vs < 0 ? -vs : vs);
            end
            ST_M3:
            begin
                p_reg   <= ONE_Q30 - sqv;
                idx_reg <= idx_reg + 4'd1;
            end
            ST_SR:
            begin
                s_reg <= negx_reg ? -vs : vs;
                p_reg <= ONE_Q30;
            end
            ST_SCEND:
            begin
                sc_reg[{ang_reg, 1'b0}] <= 16'(sin_r);
                sc_reg[{ang_reg, 1'b1}] <= 16'(cos_r);
                ang_reg <= ang_reg + 2'd1;
                ph_reg  <= PH_XZ;
                ei_reg  <= 2'd0;
                ej_reg  <= 2'd0;
                ek_reg  <= 2'd0;
            end
            ST_MAT:
            begin
                if (!is_last_term)
                    ek_reg <= ek_reg + 2'd1;
                else
                begin
                    ek_reg <= 2'd0;
                    if (ej_reg != last_j)
                        ej_reg <= ej_reg + 2'd1;
                    else
                    begin
                        ej_reg <= 2'd0;
                        ei_reg <= ei_reg + 2'd1;
                    end
                end
            end
            ST_MWAIT:
            begin
                ph_reg <= ph_reg + 3'd1;
                ei_reg <= 2'd0;
                ej_reg <= 2'd0;
                ek_reg <= 2'd0;
            end
            ST_FIRST:
            begin
                for (int i = 0; i < 9; i++)
                    rel_reg[i] <= r_reg[i];
                for (int i = 0; i < 3; i++)
                begin
                    tn_reg[i] <= tin[i];
                    tr_reg[i] <= tin[i];
                end
            end
            ST_DONE:
            begin
                if (done_fire)
                begin
                    for (int i = 0; i < 9; i++)
                        orot_reg[i] <= rel_reg[i];
                    for (int i = 0; i < 3; i++)
                        otr_reg[i] <= tr_reg[i];
                end
            end
            default:
            begin
            end
        endcase

        // multiply-accumulate writeback, in the cycle after the issue
        mfirst_reg <= (ek_reg == 2'd0);
        mlast_reg  <= is_last_term;
        mph_reg    <= ph_reg;
        mi_reg     <= ei_reg;
        mj_reg     <= ej_reg;
        if (mv_reg)
        begin
            acc_reg <= sum;
            if (mlast_reg)
            begin
                case (mph_reg)
                    PH_XZ:   rxz_reg[widx] <= 16'(r14);
                    PH_YM:   r_reg[widx]   <= sat16((AW+1)'(r14));
                    PH_REL:  rel_reg[widx] <= sat16((AW+1)'(r14));
                    PH_TS:   tn_reg[mi_reg] <= sat32((AW+1)'(r15));
                    default: tr_reg[mi_reg] <= sat32((AW+1)'(tn_reg[mi_reg]) - (AW+1)'(r14));
                endcase
            end
        end
    end

    assign result.valid  = out_valid_reg;
    assign result.r00    = orot_reg[0];
    assign result.r01    = orot_reg[1];
    assign result.r02    = orot_reg[2];
    assign result.r10    = orot_reg[3];
    assign result.r11    = orot_reg[4];
    assign result.r12    = orot_reg[5];
    assign result.r20    = orot_reg[6];
    assign result.r21    = orot_reg[7];
    assign result.r22    = orot_reg[8];
    assign result.out_tx = otr_reg[0];
    assign result.out_ty = otr_reg[1];
    assign result.out_tz = otr_reg[2];

endmodule

FILE: rtl/relative_pose_from_euler_top.sv
// Top level of the relative pose block: config register, front end queue
// and back end sequencer. Depends on rpe_pkg, rpe_if, rpe_front, rpe_back.
//
//   channel   dir   payload
//   pose      in    angle_x/y/z Q3.13, shift_x/y/z Q16.16
//   result    out   r00..r22 Q2.14, out_tx/ty/tz Q16.16
//   cfg       in    translation_scale Q1.15 (always ready)
//
// Each item is worked through the single shared multiplier: eleven series
// steps per angle, each through states ST_M1, ST_M2 and ST_M3, then one
// product per cycle for the matrix and translation sums. The first frame
// after reset skips the relative sums. Reset clears the queue, the
// previous pose and the first-frame flag. Up to two items queue while
// the back end works or while a result waits in the output register.
module relative_pose_from_euler_top import rpe_pkg::*; (
    input  logic      clk,
    input  logic      rst_n,
    rpe_in_if.sink    pose,
    rpe_out_if.source result,
    rpe_cfg_if.sink   cfg
);

    logic [15:0] scale_reg;
    qitem_t      q_item;
    qctl_t       q_stat;
    logic        q_pop;

    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            scale_reg <= SCALE_RESET;
        else if (cfg.valid)
            scale_reg <= cfg.data;
    end

    rpe_front u_front (
        .clk    (clk),
        .rst_n  (rst_n),
        .pose   (pose),
        .q_item (q_item),
        .q_stat (q_stat),
        .q_pop  (q_pop)
    );

    rpe_back u_back (
        .clk    (clk),
        .rst_n  (rst_n),
        .q_item (q_item),
        .q_stat (q_stat),
        .q_pop  (q_pop),
        .scale  (scale_reg),
        .result (result)
    );

endmodule

FILE: verif/relative_pose_from_euler_checker.sv
// Checker for the relative pose block: watches the pose, result and config
// channels, predicts each result and compares it. Depends on rpe_pkg, rpe_if.
`timescale 1ns / 100ps

module relative_pose_from_euler_checker import rpe_pkg::*; (
    input  logic clk,
    input  logic rst_n,
    rpe_in_if    pose,
    rpe_out_if   result,
    rpe_cfg_if   cfg,
    output int   fail_count,
    output int   pending
);

    localparam longint PI_Q30  = 64'sd3373259426;
    localparam longint ONE_Q30 = 64'sd1073741824;

    typedef struct packed {
        logic [8:0][15:0] rot;
        logic [2:0][31:0] tr;
    } rel_pose_t;

    rel_pose_t expected_poses[$];

    longint    last_rot[9];
    longint    last_tr[3];
    bit        first_frame;
    longint    scale;

    function automatic longint round_shr(longint v, int sh);
        v = v + (64'sd1 <<< (sh - 1));
        return v >>> sh;
    endfunction

    function automatic longint clamp(longint v, int bits);
        longint hi;
        longint lo;
        hi = (64'sd1 <<< (bits - 1)) - 1;
        lo = -hi - 1;
        return v > hi ? hi : (v < lo ? lo : v);
    endfunction

    function automatic void sin_cos(input logic signed [15:0] a,
                                    output longint s, output longint c);
        longint x;
        longint ax;
        longint x2;
        longint ps;
        longint pc;
        bit     flip;
        bit     negx;
        x = longint'(a) * 131072;
        flip = 0;
        if (2 * x > PI_Q30)
        begin
            x = x - PI_Q30;
            flip = 1;
        end
        else if (2 * x < -PI_Q30)
        begin
            x = x + PI_Q30;
            flip = 1;
        end
        negx = x < 0;
        ax = negx ? -x : x;
        x2 = round_shr(ax * ax, 30);
        ps = ONE_Q30;
        for (int k = 10; k >= 2; k -= 2)
            ps = ONE_Q30 - round_shr(ps * x2, 30) / longint'(k * (k + 1));
        s = round_shr(ax * ps, 30);
        if (negx)
            s = -s;
        pc = ONE_Q30;
        for (int k = 11; k >= 1; k -= 2)
            pc = ONE_Q30 - round_shr(pc * x2, 30) / longint'(k * (k + 1));
        c = pc;
        if (flip)
        begin
            s = -s;
            c = -c;
        end
        s = round_shr(s, SC_SHIFT);
        c = round_shr(c, SC_SHIFT);
    endfunction

    function automatic void mat3(input longint a[9], input longint b[9], output longint p[9]);
        for (int i = 0; i < 3; i++)
            for (int j = 0; j < 3; j++)
                p[i*3+j] = round_shr(a[i*3] * b[j] + a[i*3+1] * b[3+j] + a[i*3+2] * b[6+j],
                                     ROT_FRAC_BITS);
    endfunction

    function automatic rel_pose_t predict_relative(input pose_t p);
        longint    one;
        longint    sx, cx, sy, cy, sz, cz;
        longint    rx[9], ry[9], rz[9], m[9], r[9], rel[9];
        longint    t[3], tn[3], tr[3];
        rel_pose_t res;
        one = 64'sd1 <<< ROT_FRAC_BITS;
        sin_cos(p.angle_x, sx, cx);
        sin_cos(p.angle_y, sy, cy);
        sin_cos(p.angle_z, sz, cz);
        t[0] = p.shift_x;
        t[1] = p.shift_y;
        t[2] = p.shift_z;
        rx = '{one, 0, 0, 0, cx, -sx, 0, sx, cx};
        ry = '{cy, 0, sy, 0, one, 0, -sy, 0, cy};
        rz = '{cz, -sz, 0, sz, cz, 0, 0, 0, one};
        mat3(rx, rz, m);
        mat3(ry, m, r);
        for (int i = 0; i < 9; i++)
            r[i] = clamp(r[i], 16);
        if (first_frame)
        begin
            rel = r;
            tn = t;
            tr = t;
            first_frame = 0;
        end
        else
        begin
            for (int i = 0; i < 3; i++)
                tn[i] = clamp(round_shr(t[i] * scale, SCALE_SHIFT), 32);
            // R * Rprev^T
            for (int i = 0; i < 3; i++)
                for (int j = 0; j < 3; j++)
                    rel[i*3+j] = clamp(round_shr(r[i*3] * last_rot[j*3]
                        + r[i*3+1] * last_rot[j*3+1] + r[i*3+2] * last_rot[j*3+2],
                        ROT_FRAC_BITS), 16);
            for (int i = 0; i < 3; i++)
                tr[i] = clamp(tn[i] - round_shr(rel[i*3] * last_tr[0]
                    + rel[i*3+1] * last_tr[1] + rel[i*3+2] * last_tr[2], ROT_FRAC_BITS), 32);
        end
        last_rot = r;
        last_tr = tn;
        for (int i = 0; i < 9; i++)
            res.rot[8-i] = rel[i][15:0];
        for (int i = 0; i < 3; i++)
            res.tr[2-i] = tr[i][31:0];
        return res;
    endfunction

    task automatic report(input string what, input longint got, input longint want);
        $display("[%0t] mismatch %s: got %0d expected %0d", $time, what, got, want);
        fail_count++;
    endtask

    task automatic compare_result();
        rel_pose_t got;
        rel_pose_t want;
        got.rot = {result.r00, result.r01, result.r02, result.r10, result.r11, result.r12,
                   result.r20, result.r21, result.r22};
        got.tr = {result.out_tx, result.out_ty, result.out_tz};
        if (expected_poses.size() == 0)
        begin
            report("unexpected result item", 1, 0);
            return;
        end
        want = expected_poses.pop_front();
        for (int i = 0; i < 9; i++)
            if (got.rot[8-i] !== want.rot[8-i])
                report($sformatf("r%0d%0d", i / 3, i % 3), $signed(got.rot[8-i]),
                       $signed(want.rot[8-i]));
        for (int i = 0; i < 3; i++)
            if (got.tr[2-i] !== want.tr[2-i])
                report($sformatf("t%0d", i), $signed(got.tr[2-i]), $signed(want.tr[2-i]));
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            expected_poses.delete();
            last_rot = '{default: 0};
            last_tr = '{default: 0};
            first_frame = 1;
            scale = SCALE_RESET;
        end
        else
        begin
            if (cfg.valid && cfg.ready)
                scale = cfg.data;
            if (pose.valid && pose.ready)
                expected_poses.insert(expected_poses.size(),
                    predict_relative({pose.angle_x, pose.angle_y, pose.angle_z,
                                      pose.shift_x, pose.shift_y, pose.shift_z}));
            if (result.valid && result.ready)
                compare_result();
        end
        pending = expected_poses.size();
    end

    initial
    begin
        fail_count = 0;
        pending = 0;
    end

endmodule

FILE: verif/relative_pose_from_euler_top_test.sv
// Testbench top for the relative pose block: clock, reset, pose and config
// stimulus, result back-pressure and verdict. Depends on rpe_pkg, rpe_if,
// relative_pose_from_euler_top and relative_pose_from_euler_checker.
`timescale 1ns / 100ps

module relative_pose_from_euler_top_test import rpe_pkg::*; ();

    localparam int CYCLE_LIMIT = 1500000;
    localparam int ITEMS_PER_PHASE = 90;

    logic clk;
    logic rst_n;
    bit   quiet;
    int   fail_count;
    int   pending;
    int   cycles;
    int   sent;

    rpe_in_if  pose_ch();
    rpe_out_if res_ch();
    rpe_cfg_if cfg_ch();

    relative_pose_from_euler_top i_dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .pose   (pose_ch),
        .result (res_ch),
        .cfg    (cfg_ch)
    );

    relative_pose_from_euler_checker i_checker (
        .clk        (clk),
        .rst_n      (rst_n),
        .pose       (pose_ch),
        .result     (res_ch),
        .cfg        (cfg_ch),
        .fail_count (fail_count),
        .pending    (pending)
    );

    initial
    begin
        clk = 0;
        forever #1 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d results outstanding", cycles, pending);
            $display("Simulation FAILED");
            $finish;
        end
    end

    // result back-pressure
    always @(posedge clk)
        res_ch.ready <= quiet || ($urandom_range(99) >= 7);

    task automatic send_pose(input pose_t p);
        while (!quiet && $urandom_range(99) < 7)
        begin
            pose_ch.valid <= 0;
            @(posedge clk);
        end
        pose_ch.valid   <= 1;
        pose_ch.angle_x <= p.angle_x;
        pose_ch.angle_y <= p.angle_y;
        pose_ch.angle_z <= p.angle_z;
        pose_ch.shift_x <= p.shift_x;
        pose_ch.shift_y <= p.shift_y;
        pose_ch.shift_z <= p.shift_z;
        @(posedge clk);
        while (!pose_ch.ready)
            @(posedge clk);
        sent++;
    endtask

    task automatic drain();
        pose_ch.valid <= 0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
    endtask

    task automatic write_scale(input logic [15:0] value);
        drain();
        cfg_ch.valid <= 1;
        cfg_ch.data  <= value;
        @(posedge clk);
        while (!cfg_ch.ready)
            @(posedge clk);
        cfg_ch.valid <= 0;
    endtask

    function automatic pose_t random_pose();
        pose_t p;
        if ($urandom_range(9) < 7)
        begin
            // typical camera motion: moderate angles, small translations
            p.angle_x = 16'($signed($urandom_range(0, 25736)) - 12868);
            p.angle_y = 16'($signed($urandom_range(0, 25736)) - 12868);
            p.angle_z = 16'($signed($urandom_range(0, 25736)) - 12868);
            p.shift_x = $signed($urandom_range(0, 2097152)) - 1048576;
            p.shift_y = $signed($urandom_range(0, 2097152)) - 1048576;
            p.shift_z = $signed($urandom_range(0, 2097152)) - 1048576;
        end
        else
        begin
            p.angle_x = 16'($urandom);
            p.angle_y = 16'($urandom);
            p.angle_z = 16'($urandom);
            p.shift_x = $urandom;
            p.shift_y = $urandom;
            p.shift_z = $urandom;
        end
        return p;
    endfunction

    initial
    begin
        pose_t          p;
        logic [15:0]    phase_scale [5];
        rst_n = 0;
        quiet = 0;
        cycles = 0;
        sent = 0;
        pose_ch.valid = 0;
        pose_ch.angle_x = 0;
        pose_ch.angle_y = 0;
        pose_ch.angle_z = 0;
        pose_ch.shift_x = 0;
        pose_ch.shift_y = 0;
        pose_ch.shift_z = 0;
        res_ch.ready = 0;
        cfg_ch.valid = 0;
        cfg_ch.data = 0;
        repeat (10) @(posedge clk);
        rst_n <= 1;
        @(posedge clk);

        // directed: first frame, pi boundaries, extremes, at reset scale
        send_pose('{angle_x: 16'sd0, angle_y: 16'sd0, angle_z: 16'sd0,
                    shift_x: 32'sh7fffffff, shift_y: 32'sh80000000, shift_z: 32'sd65536});
        send_pose('{angle_x: 16'sd0, angle_y: 16'sd0, angle_z: 16'sd0,
                    shift_x: 32'sh7fffffff, shift_y: 32'sh80000000, shift_z: 32'sd0});
        send_pose('{angle_x: 16'sh7fff, angle_y: 16'sh8000, angle_z: 16'sh7fff,
                    shift_x: 32'sh80000000, shift_y: 32'sh7fffffff, shift_z: -32'sd1});
        send_pose('{angle_x: 16'sh8000, angle_y: 16'sh7fff, angle_z: 16'sh8000,
                    shift_x: 32'sd0, shift_y: 32'sd0, shift_z: 32'sd0});
        send_pose('{angle_x: 16'sd12867, angle_y: 16'sd12868, angle_z: -16'sd12868,
                    shift_x: 32'sd1, shift_y: -32'sd1, shift_z: 32'sd1});
        send_pose('{angle_x: -16'sd12869, angle_y: -16'sd12867, angle_z: 16'sd12869,
                    shift_x: 32'sd32768, shift_y: -32'sd32768, shift_z: 32'sd0});
        send_pose('{angle_x: 16'sd25736, angle_y: -16'sd25736, angle_z: 16'sd6434,
                    shift_x: 32'sd0, shift_y: 32'sd0, shift_z: 32'sh7fffffff});
        send_pose('{angle_x: 16'sd1, angle_y: -16'sd1, angle_z: 16'sd0,
                    shift_x: -32'sd65536, shift_y: 32'sd65536, shift_z: 32'sh80000000});

        // saturating scale and zero scale on extreme shifts
        write_scale(16'hffff);
        send_pose('{angle_x: 16'sd0, angle_y: 16'sd0, angle_z: 16'sd0,
                    shift_x: 32'sh7fffffff, shift_y: 32'sh80000000, shift_z: 32'sd1});
        send_pose('{angle_x: 16'sd25736, angle_y: 16'sd0, angle_z: -16'sd25736,
                    shift_x: 32'sh80000000, shift_y: 32'sh7fffffff, shift_z: -32'sd1});
        write_scale(16'd0);
        send_pose('{angle_x: 16'sh7fff, angle_y: 16'sh7fff, angle_z: 16'sh7fff,
                    shift_x: 32'sh7fffffff, shift_y: 32'sh7fffffff, shift_z: 32'sh7fffffff});
        send_pose('{angle_x: 16'sh8000, angle_y: 16'sh8000, angle_z: 16'sh8000,
                    shift_x: 32'sh80000000, shift_y: 32'sh80000000, shift_z: 32'sh80000000});

        phase_scale = '{16'd32768, 16'd0, 16'hffff, 16'($urandom), SCALE_RESET};
        for (int ph = 0; ph < 5; ph++)
        begin
            write_scale(phase_scale[ph]);
            quiet = (ph == 3);
            for (int n = 0; n < ITEMS_PER_PHASE; n++)
            begin
                p = random_pose();
                send_pose(p);
                if (ph == 1 && n == ITEMS_PER_PHASE / 2)
                    drain();
            end
        end
        quiet = 0;

        drain();
        repeat (300) @(posedge clk);
        $display("%0d pose items sent under reset, unity, zero, saturating and random", sent);
        $display("scales, with pi boundaries, field extremes and output stalls");
        if (fail_count == 0 && pending == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
